// ===== design/sync_packet_deframer_sum16_assert.svh =====
// Assertion macros for the packet deframer
`ifndef SYNC_PACKET_DEFRAMER_SUM16_ASSERT_SVH
`define SYNC_PACKET_DEFRAMER_SUM16_ASSERT_SVH
`ifndef SYNTHESIS
`define SPDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spdf assertion failed");
`define SPDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spdf assertion failed");
`else
`define SPDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/spdf_pkg.sv =====
// Package: constants, types and helpers of the packet deframer
`timescale 1ns / 1ps
package spdf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned LEFT_W  = 6;

  localparam int unsigned HAS_DATA_BIT = 7;
  localparam int unsigned BATCH_BIT    = 6;
  localparam int unsigned COUNT_SHIFT  = 2;
  localparam logic [3:0]  COUNT_MASK   = 4'hF;

  localparam logic [BYTE_W-1:0] SYNC_S = 8'h73;
  localparam logic [BYTE_W-1:0] SYNC_N = 8'h6E;
  localparam logic [BYTE_W-1:0] SYNC_P = 8'h70;
  localparam logic [SUM_W-1:0]  SYNC_SUM = 16'(SYNC_S) + 16'(SYNC_N) + 16'(SYNC_P);

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  function automatic logic [BYTE_W-1:0] sync_byte(input logic [1:0] prog);
    logic [BYTE_W-1:0] r;
    case (prog)
      2'd1:    r = SYNC_N;
      2'd2:    r = SYNC_P;
      default: r = SYNC_S;
    endcase
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] words_announced(input logic [BYTE_W-1:0] t);
    logic [IDX_W-1:0] r;
    if (!t[HAS_DATA_BIT]) begin
      r = '0;
    end else if (!t[BATCH_BIT]) begin
      r = IDX_W'(1);
    end else begin
      r = t[COUNT_SHIFT +: IDX_W] & COUNT_MASK;
    end
    return r;
  endfunction

endpackage

// ===== design/spdf_if.sv =====
// Interfaces: byte input channel and result output channel
`timescale 1ns / 1ps
interface spdf_in_if;
  import spdf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface spdf_out_if;
  import spdf_pkg::*;
  logic              valid;
  logic              ready;
  logic              status;
  logic [BYTE_W-1:0] reg_address;
  logic              has_data;
  logic [IDX_W-1:0]  word_index;
  logic [WORD_W-1:0] data_word;
  logic              last;
  modport source (output valid, output status, output reg_address, output has_data,
                  output word_index, output data_word, output last, input ready);
  modport sink (input valid, input status, input reg_address, input has_data,
                input word_index, input data_word, input last, output ready);
endinterface

// ===== design/spdf_store.sv =====
// Payload word store: one write port, one registered read port
`timescale 1ns / 1ps
module spdf_store #(
  parameter int unsigned MAX_WORDS = 15
) (
  input  logic                          clk_i,
  input  spdf_pkg::mem_req_t            req_i,
  output logic [spdf_pkg::WORD_W-1:0]   rd_data_o
);
  import spdf_pkg::*;

  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [WORD_W-1:0] mem [MAX_WORDS];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/sync_packet_deframer_sum16.sv =====
// Top level: sync search, packet parse, checksum and word emission
// channel  dir  payload
// in_i     in   rx_byte
// out_o    out  status, reg_address, has_data, word_index, data_word, last
// One byte a cycle while parsing; the checksum low byte waits for a free output register.
// A good packet with data emits each word by a store read and then an output load, which
// waits out output stalls; no byte is taken until the last word is loaded.
// Reset clears the parser and output valid; the payload store keeps no reset contents.
`timescale 1ns / 1ps
`include "sync_packet_deframer_sum16_assert.svh"
module sync_packet_deframer_sum16 #(
  parameter int unsigned MAX_WORDS = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spdf_in_if.sink    in_i,
  spdf_out_if.source out_o
);
  import spdf_pkg::*;

  localparam logic [2:0] PH_SYNC = 3'd0;
  localparam logic [2:0] PH_TYPE = 3'd1;
  localparam logic [2:0] PH_ADDR = 3'd2;
  localparam logic [2:0] PH_PAY  = 3'd3;
  localparam logic [2:0] PH_CKHI = 3'd4;
  localparam logic [2:0] PH_CKLO = 3'd5;
  localparam logic [2:0] PH_READ = 3'd6;
  localparam logic [2:0] PH_LOAD = 3'd7;

  localparam logic [IDX_W-1:0] MaxW = IDX_W'(MAX_WORDS);

  logic [2:0]        phase_q, phase_d;
  logic [1:0]        sync_q, sync_d;
  logic [BYTE_W-1:0] type_q, type_d;
  logic [BYTE_W-1:0] addr_q, addr_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [BYTE_W-1:0] ckhi_q, ckhi_d;
  logic [IDX_W-1:0]  words_q, words_d;
  logic [IDX_W-1:0]  wcnt_q, wcnt_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [23:0]       word_q, word_d;

  logic              ov_q, ov_d;
  logic              st_q, st_d;
  logic [BYTE_W-1:0] ra_q, ra_d;
  logic              hd_q, hd_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [WORD_W-1:0] dw_q, dw_d;
  logic              last_q, last_d;

  logic              in_fire, out_free, out_load;
  logic [BYTE_W-1:0] b;
  logic [1:0]        prog;
  logic [IDX_W-1:0]  ann;
  mem_req_t          req;
  logic [WORD_W-1:0] rd_data;

  spdf_store #(.MAX_WORDS(MAX_WORDS)) u_store (
    .clk_i     (clk_i),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  assign b        = in_i.rx_byte;
  assign out_free = !ov_q || out_o.ready;
  assign in_i.ready = (phase_q inside {PH_SYNC, PH_TYPE, PH_ADDR, PH_PAY, PH_CKHI})
                      || (phase_q == PH_CKLO && out_free);
  assign in_fire  = in_i.valid && in_i.ready;
  assign prog     = (sync_q > 2'd2) ? 2'd0 : sync_q;
  assign ann      = words_announced(type_q);

  always_comb begin
    phase_d = phase_q;
    sync_d  = sync_q;
    type_d  = type_q;
    addr_d  = addr_q;
    left_d  = left_q;
    sum_d   = sum_q;
    ckhi_d  = ckhi_q;
    words_d = words_q;
    wcnt_d  = wcnt_q;
    k_d     = k_q;
    word_d  = word_q;
    out_load = 1'b0;
    st_d    = st_q;
    ra_d    = ra_q;
    hd_d    = hd_q;
    idx_d   = idx_q;
    dw_d    = dw_q;
    last_d  = last_q;
    req.we    = 1'b0;
    req.waddr = wcnt_q;
    req.wdata = {word_q, b};
    req.re    = 1'b0;
    req.raddr = k_q;
    case (phase_q)
      PH_SYNC: begin
        if (in_fire) begin
          if (b == sync_byte(prog)) begin
            if (prog == 2'd2) begin
              sync_d  = 2'd0;
              sum_d   = SYNC_SUM;
              phase_d = PH_TYPE;
            end else begin
              sync_d = prog + 2'd1;
            end
          end else begin
            sync_d = (b == SYNC_S) ? 2'd1 : 2'd0;
          end
        end
      end
      PH_TYPE: begin
        if (in_fire) begin
          type_d  = b;
          sum_d   = sum_q + SUM_W'(b);
          phase_d = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (in_fire) begin
          addr_d  = b;
          sum_d   = sum_q + SUM_W'(b);
          left_d  = {ann, 2'b00};
          words_d = (ann > MaxW) ? MaxW : ann;
          wcnt_d  = '0;
          phase_d = (ann != '0) ? PH_PAY : PH_CKHI;
        end
      end
      PH_PAY: begin
        if (in_fire) begin
          sum_d  = sum_q + SUM_W'(b);
          word_d = {word_q[15:0], b};
          left_d = left_q - LEFT_W'(1);
          if (left_q[1:0] == 2'd1) begin
            req.we = (wcnt_q < MaxW);
            wcnt_d = wcnt_q + IDX_W'(1);
          end
          if (left_q == LEFT_W'(1)) begin
            phase_d = PH_CKHI;
          end
        end
      end
      PH_CKHI: begin
        if (in_fire) begin
          ckhi_d  = b;
          phase_d = PH_CKLO;
        end
      end
      PH_CKLO: begin
        if (in_fire) begin
          sync_d = 2'd0;
          ra_d   = addr_q;
          hd_d   = 1'b0;
          idx_d  = '0;
          dw_d   = '0;
          last_d = 1'b1;
          if ({ckhi_q, b} != sum_q) begin
            out_load = 1'b1;
            st_d     = 1'b1;
            phase_d  = PH_SYNC;
          end else if (words_q == '0) begin
            out_load = 1'b1;
            st_d     = 1'b0;
            phase_d  = PH_SYNC;
          end else begin
            k_d     = '0;
            phase_d = PH_READ;
          end
        end
      end
      PH_READ: begin
        req.re  = 1'b1;
        phase_d = PH_LOAD;
      end
      PH_LOAD: begin
        if (out_free) begin
          out_load = 1'b1;
          st_d     = 1'b0;
          ra_d     = addr_q;
          hd_d     = 1'b1;
          idx_d    = k_q;
          dw_d     = rd_data;
          last_d   = (k_q == words_q - IDX_W'(1));
          if (k_q == words_q - IDX_W'(1)) begin
            phase_d = PH_SYNC;
          end else begin
            k_d     = k_q + IDX_W'(1);
            phase_d = PH_READ;
          end
        end
      end
      default: begin
        phase_d = PH_SYNC;
      end
    endcase
    if (out_load) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC;
      sync_q  <= 2'd0;
      type_q  <= '0;
      addr_q  <= '0;
      left_q  <= '0;
      sum_q   <= '0;
      ckhi_q  <= '0;
      words_q <= '0;
      wcnt_q  <= '0;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      sync_q  <= sync_d;
      type_q  <= type_d;
      addr_q  <= addr_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
      ckhi_q  <= ckhi_d;
      words_q <= words_d;
      wcnt_q  <= wcnt_d;
      k_q     <= k_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    st_q   <= st_d;
    ra_q   <= ra_d;
    hd_q   <= hd_d;
    idx_q  <= idx_d;
    dw_q   <= dw_d;
    last_q <= last_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.status      = st_q;
  assign out_o.reg_address = ra_q;
  assign out_o.has_data    = hd_q;
  assign out_o.word_index  = idx_q;
  assign out_o.data_word   = dw_q;
  assign out_o.last        = last_q;

  `SPDF_ASSERT_NXT(a_read_then_load, clk_i, rst_ni, phase_q == PH_READ, phase_q == PH_LOAD)
  `SPDF_ASSERT_IMP(a_more_words_pending, clk_i, rst_ni, ov_q && hd_q && !last_q,
                   phase_q == PH_READ || phase_q == PH_LOAD)
  `SPDF_ASSERT_IMP(a_bad_sum_no_data, clk_i, rst_ni, ov_q && st_q, !hd_q && last_q)
  `SPDF_ASSERT_IMP(a_sync_range, clk_i, rst_ni, 1'b1, sync_q != 2'd3)

endmodule
